// ===== rtl/bsk_pkg.sv =====
// Shared types and constants for the B-spline box kernel evaluator.
`default_nettype none

package bsk_pkg;

    localparam int NUM_STAGES  = 8;
    localparam int LANE_STAGES = 5;
    localparam int NUM_AXES    = 3;
    localparam int COORD_W     = 32;
    localparam int VAL_W       = 31;
    localparam int MAG_W       = 33;
    localparam int CFG_ADDR_W  = 3;

    localparam logic [VAL_W-1:0] Q30_ONE = 31'h4000_0000;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CENTER_X    = 3'd0,
        REG_CENTER_Y    = 3'd1,
        REG_CENTER_Z    = 3'd2,
        REG_INV_RADIUS  = 3'd3,
        REG_ACTIVE_DIMS = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [MAG_W-1:0] mag;
        logic             neg;
    } axis_res_t;

endpackage

`default_nettype wire

// ===== rtl/bsk_axis_lane.sv =====
// Per-axis pipeline: distance, scaling, spline piece selection, value and slope.
`default_nettype none

module bsk_axis_lane import bsk_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                    aclk,
    input  wire logic [LANE_STAGES-1:0]  stage_en,
    input  wire logic [COORD_W-1:0]      point,
    input  wire logic [COORD_W-1:0]      center,
    input  wire logic [COORD_W-1:0]      inv_radius,
    input  wire logic                    active,
    output axis_res_t                    res
);

    localparam int F   = FRAC_BITS;
    localparam int ZW  = 64 - F;
    localparam int SHL = (2 * F < 30) ? 30 - 2 * F : 0;
    localparam int SHR = (2 * F >= 30) ? 2 * F - 30 : 0;
    localparam int VW  = 2 * F + 1 + SHL;

    localparam logic [ZW-1:0]  Z_ONE  = {{(ZW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
    localparam logic [F:0]     ONE    = {1'b1, {F{1'b0}}};
    localparam logic [F:0]     HALF   = {2'b01, {(F-1){1'b0}}};
    localparam logic [2*F:0]   ONE_SQ = {1'b1, {(2*F){1'b0}}};

    // Stage 1: absolute distance from the center.
    logic [32:0] diff_pos, diff_neg, ad_next, ad_reg;
    logic        s1_neg_reg;

    assign diff_pos = {point[31], point} - {center[31], center};
    assign diff_neg = {center[31], center} - {point[31], point};
    assign ad_next  = diff_pos[32] ? diff_neg : diff_pos;

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            ad_reg     <= ad_next;
            s1_neg_reg <= !diff_pos[32] && (diff_pos != '0);
        end
    end

    // Stage 2: scale by the reciprocal radius.
    logic [64:0] prod_full;
    logic [63:0] prod_reg;
    logic        s2_neg_reg;

    assign prod_full = ad_reg * inv_radius;

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            prod_reg   <= prod_full[63:0];
            s2_neg_reg <= s1_neg_reg;
        end
    end

    // Stage 3: pick the spline piece and its local coordinate.
    logic [F:0]   z_low, w_full;
    logic         piece1_next;
    logic [F-1:0] u_next, u_reg;
    logic         s3_piece1_reg, s3_far_reg, s3_neg_reg;

    assign z_low       = prod_reg[2*F:F];
    assign w_full      = ONE - z_low;
    assign piece1_next = z_low <= HALF;
    assign u_next      = piece1_next ? z_low[F-1:0] : w_full[F-1:0];

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            u_reg         <= u_next;
            s3_piece1_reg <= piece1_next;
            s3_far_reg    <= prod_reg[63:F] > Z_ONE;
            s3_neg_reg    <= s2_neg_reg;
        end
    end

    // Stage 4: square and slope products.
    logic [2*F-1:0]  sq_next, sq_reg;
    logic [F+31:0]   ui_next, ui_reg;
    logic            s4_piece1_reg, s4_far_reg, s4_neg_reg;

    assign sq_next = u_reg * u_reg;
    assign ui_next = u_reg * inv_radius;

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            sq_reg        <= sq_next;
            ui_reg        <= ui_next;
            s4_piece1_reg <= s3_piece1_reg;
            s4_far_reg    <= s3_far_reg;
            s4_neg_reg    <= s3_neg_reg;
        end
    end

    // Stage 5: axis value in Q1.30 and slope magnitude.
    logic [2*F:0]     twice_sq, v2f;
    logic [VW-1:0]    v_wide;
    logic [VAL_W-1:0] v_q30;
    logic [MAG_W-1:0] mag_val;
    axis_res_t        res_next, res_reg;

    assign twice_sq = {sq_reg, 1'b0};
    assign v2f      = s4_piece1_reg ? ONE_SQ - twice_sq : twice_sq;
    assign v_wide   = VW'(v2f) << SHL;
    assign v_q30    = VAL_W'(v_wide >> SHR);
    assign mag_val  = MAG_W'(ui_reg >> (F - 2));

    always_comb begin
        if (!active) begin
            res_next.value = Q30_ONE;
            res_next.mag   = '0;
        end else if (s4_far_reg) begin
            res_next.value = '0;
            res_next.mag   = '0;
        end else begin
            res_next.value = v_q30;
            res_next.mag   = mag_val;
        end
        res_next.neg = active && s4_neg_reg;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[4]) begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ===== rtl/bsk_combine.sv =====
// Product stages that form the kernel value and the saturated gradient.
`default_nettype none

module bsk_combine import bsk_pkg::*; (
    input  wire logic                             aclk,
    input  wire logic [NUM_STAGES-LANE_STAGES-1:0] stage_en,
    input  wire axis_res_t                        res [NUM_AXES],
    output logic [VAL_W-1:0]                      kernel_value,
    output logic [NUM_AXES-1:0][COORD_W-1:0]      grad,
    output logic                                  in_support
);

    function automatic logic [COORD_W-1:0] sat_grad(input logic [MAG_W-1:0] m,
                                                    input logic neg);
        logic [MAG_W-1:0] m_neg;
        m_neg = ~m + MAG_W'(1);
        if (neg) begin
            sat_grad = (m > MAG_W'(33'h0_8000_0000)) ? 32'h8000_0000 : m_neg[31:0];
        end else begin
            sat_grad = (m > MAG_W'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF : m[31:0];
        end
    endfunction

    // Stage 6: first product step.
    logic [2*VAL_W-1:0]       kp_full;
    logic [MAG_W+VAL_W-1:0]   gp_full [NUM_AXES];
    logic [VAL_W-1:0]         kp_reg, v1_reg, v2_reg;
    logic [MAG_W-1:0]         gp_reg [NUM_AXES];
    logic [NUM_AXES-1:0]      s6_neg_reg;

    assign kp_full    = res[0].value * res[1].value;
    assign gp_full[0] = res[0].mag * res[1].value;
    assign gp_full[1] = res[1].mag * res[0].value;
    assign gp_full[2] = res[2].mag * res[0].value;

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            kp_reg <= VAL_W'(kp_full >> 30);
            for (int i = 0; i < NUM_AXES; i++) begin
                gp_reg[i]     <= MAG_W'(gp_full[i] >> 30);
                s6_neg_reg[i] <= res[i].neg;
            end
            v1_reg <= res[1].value;
            v2_reg <= res[2].value;
        end
    end

    // Stage 7: second product step.
    logic [2*VAL_W-1:0]       k_full;
    logic [MAG_W+VAL_W-1:0]   g_full [NUM_AXES];
    logic [VAL_W-1:0]         k_reg;
    logic [MAG_W-1:0]         g_reg [NUM_AXES];
    logic [NUM_AXES-1:0]      s7_neg_reg;

    assign k_full    = kp_reg * v2_reg;
    assign g_full[0] = gp_reg[0] * v2_reg;
    assign g_full[1] = gp_reg[1] * v2_reg;
    assign g_full[2] = gp_reg[2] * v1_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            k_reg <= VAL_W'(k_full >> 30);
            for (int i = 0; i < NUM_AXES; i++) begin
                g_reg[i] <= MAG_W'(g_full[i] >> 30);
            end
            s7_neg_reg <= s6_neg_reg;
        end
    end

    // Stage 8: sign, saturation and the output register.
    logic [VAL_W-1:0]                   kernel_reg;
    logic [NUM_AXES-1:0][COORD_W-1:0]   grad_reg;
    logic                               support_reg;

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            kernel_reg  <= k_reg;
            support_reg <= k_reg != '0;
            for (int i = 0; i < NUM_AXES; i++) begin
                grad_reg[i] <= sat_grad(g_reg[i], s7_neg_reg[i]);
            end
        end
    end

    assign kernel_value = kernel_reg;
    assign grad         = grad_reg;
    assign in_support   = support_reg;

endmodule

`default_nettype wire

// ===== rtl/bspline_box_kernel_eval.sv =====
// Top level of the tensor-product quadratic B-spline kernel evaluator.
// The slave channel takes one query point per transfer: tdata carries point_x,
// point_y and point_z as signed Q16.16 words. The master channel returns one
// result per point: tdata carries the Q1.30 kernel value and the three
// saturated Q16.16 gradient components, tuser carries the in-support flag.
// The user must set centers, reciprocal radius and the active axis count through
// the write port while no point is in flight; the block itself does not enforce it.
// A point passes eight register stages: five per-axis stages in the lanes and
// three stages that chain the axis factors and saturate the gradients, before
// m_tvalid rises.
// Throughput is one point per cycle while the receiver keeps m_tready high.
// When the receiver stalls, each stage holds its item; empty stages still fill,
// so s_tready stays high until all eight stages hold a point.
// Reset empties the pipeline and loads the default registers: center at the
// origin, a reciprocal radius of 1.0 and three active axes.
`default_nettype none

module bspline_box_kernel_eval import bsk_pkg::*; #(
    parameter int MAX_DIMS  = 3,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [95:0]            s_tdata,   // point_x, point_y, point_z
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [127:0]                m_tdata,   // kernel_value, grad_x, grad_y, grad_z
    output logic [0:0]                  m_tuser,   // in_support
    input  wire logic                   cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [31:0]            cfg_wdata
);

    logic [COORD_W-1:0] center_reg [NUM_AXES];
    logic [COORD_W-1:0] inv_radius_reg;
    logic [1:0]         active_dims_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                center_reg[i] <= '0;
            end
            inv_radius_reg  <= 32'h0001_0000;
            active_dims_reg <= 2'd3;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_CENTER_X:    center_reg[0]   <= cfg_wdata;
                REG_CENTER_Y:    center_reg[1]   <= cfg_wdata;
                REG_CENTER_Z:    center_reg[2]   <= cfg_wdata;
                REG_INV_RADIUS:  inv_radius_reg  <= cfg_wdata;
                REG_ACTIVE_DIMS: active_dims_reg <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    logic [1:0]          dims_eff;
    logic [NUM_AXES-1:0] axis_active;

    assign dims_eff = (active_dims_reg > 2'(MAX_DIMS)) ? 2'(MAX_DIMS) : active_dims_reg;

    for (genvar i = 0; i < NUM_AXES; i++) begin : g_active
        assign axis_active[i] = 2'(i) < dims_eff;
    end

    // Valid bits and per-stage load enables; a stage loads when it is empty
    // or the stage after it moves.
    logic [NUM_STAGES-1:0] valid_reg, valid_next;
    logic [NUM_STAGES:0]   stage_en;

    always_comb begin
        stage_en[NUM_STAGES] = m_tready;
        for (int k = NUM_STAGES - 1; k >= 0; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
        for (int k = 0; k < NUM_STAGES; k++) begin
            if (stage_en[k]) begin
                valid_next[k] = (k == 0) ? s_tvalid : valid_reg[(k == 0) ? 0 : k - 1];
            end else begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = stage_en[0];
    assign m_tvalid = valid_reg[NUM_STAGES-1];

    axis_res_t lane_res [NUM_AXES];

    for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
        bsk_axis_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .aclk       (aclk),
            .stage_en   (stage_en[LANE_STAGES-1:0]),
            .point      (s_tdata[i*COORD_W +: COORD_W]),
            .center     (center_reg[i]),
            .inv_radius (inv_radius_reg),
            .active     (axis_active[i]),
            .res        (lane_res[i])
        );
    end

    logic [VAL_W-1:0]                 kernel_value;
    logic [NUM_AXES-1:0][COORD_W-1:0] grad;
    logic                             in_support;

    bsk_combine u_combine (
        .aclk         (aclk),
        .stage_en     (stage_en[NUM_STAGES-1:LANE_STAGES]),
        .res          (lane_res),
        .kernel_value (kernel_value),
        .grad         (grad),
        .in_support   (in_support)
    );

    assign m_tdata = {1'b0, grad[2], grad[1], grad[0], kernel_value};
    assign m_tuser = in_support;

    a_kernel_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[30:0] <= Q30_ONE))
        else $error("kernel value above one");

    a_support_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[0] == (m_tdata[30:0] != '0)))
        else $error("in_support disagrees with kernel value");

    a_inactive_z: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (dims_eff < 2'd3)) |-> (m_tdata[126:95] == '0))
        else $error("gradient of an inactive third axis is not zero");

    a_no_dims: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (dims_eff == 2'd0)) |-> (m_tdata[30:0] == Q30_ONE))
        else $error("kernel with no active axes is not one");

    a_bubble_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !(&valid_reg) |-> s_tready)
        else $error("input stalled while the pipeline has an empty stage");

endmodule

`default_nettype wire

// ===== tb/bspline_box_kernel_eval_test.sv =====
// Self-checking testbench for the quadratic B-spline box kernel evaluator.
`timescale 1ns / 100ps

module bspline_box_kernel_eval_test import bsk_pkg::*; ();

    localparam int FRAC_BITS   = 16;
    localparam int MAX_DIMS    = 3;
    localparam int HOLD_CYCLES = 150;
    localparam int PHASE_ITEMS = 190;
    localparam int NUM_PHASES  = 10;

    localparam bit [63:0] FIX_ONE  = 64'd1 << FRAC_BITS;
    localparam bit [63:0] FIX_HALF = FIX_ONE >> 1;
    localparam bit [63:0] Q30_UNIT = 64'd1 << 30;
    localparam longint    GRAD_MAX = 64'sd2147483647;
    localparam longint    GRAD_MIN = -64'sd2147483648;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LAST  = '1;

    typedef struct packed {
        logic [30:0] kernel_value;
        logic [31:0] grad_x;
        logic [31:0] grad_y;
        logic [31:0] grad_z;
        logic        in_support;
    } kernel_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [95:0]           s_tdata   = '0;    // point_x, point_y, point_z
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [127:0]          m_tdata;           // kernel_value, grad_x, grad_y, grad_z
    logic [0:0]            m_tuser;           // in_support
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [31:0]           cfg_wdata = '0;

    bit [31:0] cfg_center [3];
    bit [31:0] cfg_inv  = 32'h0001_0000;
    bit [1:0]  cfg_dims = 2'd3;

    bit [95:0]      pending_points [$];
    kernel_result_t predicted_kernels [$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  points_queued = 0;
    int  results_seen  = 0;
    int  bad_results   = 0;
    int  config_count  = 0;
    int  hold_count    = 0;
    bit  hold_armed    = 1'b0;
    bit  point_taken   = 1'b0;

    bspline_box_kernel_eval uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic kernel_result_t eval_kernel(input bit [95:0] point_word);
        longint         d;
        longint         g;
        bit [63:0]      ad;
        bit [63:0]      zq;
        bit [63:0]      w;
        bit [63:0]      kern;
        bit [63:0]      m;
        bit [63:0]      fac [3];
        bit [63:0]      mag [3];
        bit             neg [3];
        bit [31:0]      grad [3];
        int             dims;
        kernel_result_t r;
        dims = (cfg_dims > MAX_DIMS) ? MAX_DIMS : cfg_dims;
        for (int i = 0; i < 3; i++) begin
            fac[i] = Q30_UNIT;
            mag[i] = 0;
            neg[i] = 1'b0;
            if (i < dims) begin
                d = longint'($signed(point_word[32*i +: 32])) -
                    longint'($signed(cfg_center[i]));
                ad = (d < 0) ? -d : d;
                zq = (ad * cfg_inv) >> FRAC_BITS;
                neg[i] = d > 0;
                if (zq <= FIX_HALF) begin
                    fac[i] = (FIX_ONE * FIX_ONE - 2 * zq * zq) >> (2 * FRAC_BITS - 30);
                    mag[i] = (4 * zq * cfg_inv) >> FRAC_BITS;
                end else if (zq <= FIX_ONE) begin
                    w = FIX_ONE - zq;
                    fac[i] = (2 * w * w) >> (2 * FRAC_BITS - 30);
                    mag[i] = (4 * w * cfg_inv) >> FRAC_BITS;
                end else begin
                    fac[i] = 0;
                    mag[i] = 0;
                end
            end
        end
        kern = Q30_UNIT;
        for (int i = 0; i < 3; i++)
            kern = (kern * fac[i]) >> 30;
        for (int i = 0; i < 3; i++) begin
            g = 0;
            if (i < dims) begin
                m = mag[i];
                for (int j = 0; j < 3; j++)
                    if (j != i)
                        m = (m * fac[j]) >> 30;
                if (neg[i])
                    g = (m > 64'h8000_0000) ? GRAD_MIN : -longint'(m);
                else
                    g = (m > 64'h7FFF_FFFF) ? GRAD_MAX : longint'(m);
            end
            grad[i] = g[31:0];
        end
        r.kernel_value = kern[30:0];
        r.grad_x       = grad[0];
        r.grad_y       = grad[1];
        r.grad_z       = grad[2];
        r.in_support   = kern != 0;
        return r;
    endfunction

    always @(negedge aclk) begin : point_driver
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || point_taken) begin
            if (pending_points.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tdata  <= pending_points.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin : result_sink
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_armed && hold_count < HOLD_CYCLES) begin
            hold_count++;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : result_monitor
        kernel_result_t got;
        kernel_result_t want;
        point_taken = aresetn && s_tvalid && s_tready;
        if (point_taken)
            predicted_kernels.push_back(eval_kernel(s_tdata));
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            got.kernel_value = m_tdata[30:0];
            got.grad_x       = m_tdata[62:31];
            got.grad_y       = m_tdata[94:63];
            got.grad_z       = m_tdata[126:95];
            got.in_support   = m_tuser[0];
            if (predicted_kernels.size() == 0) begin
                if (bad_results < 10)
                    $display("Unexpected result transfer: kernel %h grad %h %h %h support %b",
                             got.kernel_value, got.grad_x, got.grad_y, got.grad_z,
                             got.in_support);
                bad_results++;
            end else begin
                want = predicted_kernels.pop_front();
                if (got.kernel_value !== want.kernel_value || got.grad_x !== want.grad_x ||
                    got.grad_y !== want.grad_y || got.grad_z !== want.grad_z ||
                    got.in_support !== want.in_support) begin
                    if (bad_results < 10) begin
                        $display("Result %0d mismatch:", results_seen);
                        $display("  expected kernel %h grad %h %h %h support %b",
                                 want.kernel_value, want.grad_x, want.grad_y, want.grad_z,
                                 want.in_support);
                        $display("  actual   kernel %h grad %h %h %h support %b",
                                 got.kernel_value, got.grad_x, got.grad_y, got.grad_z,
                                 got.in_support);
                    end
                    bad_results++;
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input bit [31:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_CENTER_X:    cfg_center[0] = val;
            REG_CENTER_Y:    cfg_center[1] = val;
            REG_CENTER_Z:    cfg_center[2] = val;
            REG_INV_RADIUS:  cfg_inv = val;
            REG_ACTIVE_DIMS: cfg_dims = val[1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_config(input bit [31:0] cx, input bit [31:0] cy, input bit [31:0] cz,
                                input bit [31:0] inv, input bit [1:0] dims);
        bit [31:0] dims_word;
        dims_word      = $urandom;
        dims_word[1:0] = dims;
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_INV_RADIUS, inv);
        write_reg(REG_ACTIVE_DIMS, dims_word);
        // A write to an unused index must leave every register alone.
        write_reg(CFG_ADDR_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)), $urandom);
        config_count++;
    endtask

    task automatic set_idling(input int snd, input int rcv);
        @(posedge aclk);
        send_idle_pct = snd;
        recv_idle_pct = rcv;
    endtask

    task automatic push_point(input bit [31:0] px, input bit [31:0] py, input bit [31:0] pz);
        pending_points.push_back({pz, py, px});
        points_queued++;
    endtask

    task automatic push_random_point;
        bit [31:0] coord [3];
        bit [63:0] rnd;
        longint    span;
        longint    reach;
        longint    off;
        longint    v;
        int        pick;
        span  = (cfg_inv == 0) ? longint'(64'h1_0000_0000)
                               : longint'(64'h1_0000_0000 / cfg_inv);
        reach = span + span / 4 + 1;
        for (int i = 0; i < 3; i++)
            coord[i] = $urandom;
        if ($urandom_range(99) >= 15) begin
            for (int i = 0; i < 3; i++) begin
                pick = $urandom_range(99);
                rnd  = {$urandom, $urandom};
                if (pick >= 5) begin
                    if (pick < 20) begin
                        case ($urandom_range(5))
                            0:       off = span / 2;
                            1:       off = span;
                            2:       off = span + 1;
                            3:       off = -(span / 2);
                            4:       off = -span;
                            default: off = -span - 1;
                        endcase
                    end else begin
                        off = longint'(rnd % 64'(2 * reach + 1)) - reach;
                    end
                    v = longint'($signed(cfg_center[i])) + off;
                    if (v > GRAD_MAX)
                        v = GRAD_MAX;
                    else if (v < GRAD_MIN)
                        v = GRAD_MIN;
                    coord[i] = v[31:0];
                end
            end
        end
        push_point(coord[0], coord[1], coord[2]);
    endtask

    task automatic wait_drained;
        @(negedge aclk);
        while (results_seen < points_queued)
            @(negedge aclk);
    endtask

    initial begin : stimulus
        bit [31:0] cx;
        bit [31:0] cy;
        bit [31:0] cz;
        bit [31:0] inv;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset defaults: center at the origin, radius 1.0, three axes.
        set_idling(30, 88);
        push_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        push_point(32'h0000_8000, 32'hFFFF_8000, 32'h0000_0000);
        push_point(32'h0000_8001, 32'h0000_7FFF, 32'hFFFF_8001);
        push_point(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
        push_point(32'h0001_0001, 32'h0000_0000, 32'h0000_0000);
        push_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        push_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_4000);
        push_point(32'h0000_C000, 32'hFFFF_A000, 32'h0000_2000);
        wait_drained();

        // No active axes at all.
        apply_config(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 2'd0);
        set_idling(30, 88);
        push_point(32'h0000_4000, 32'h7FFF_FFFF, 32'h8000_0000);
        push_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        wait_drained();

        // A zero reciprocal radius makes every axis sit at the center.
        apply_config($urandom, $urandom, $urandom, 32'h0000_0000, 2'd3);
        set_idling(30, 88);
        push_point($urandom, $urandom, $urandom);
        push_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        wait_drained();

        // A large reciprocal radius drives the gradients into saturation.
        apply_config(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 2'd3);
        set_idling(30, 88);
        push_point(32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
        push_point(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        push_point(32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin cx = 32'h7FFF_FFFF; cy = 32'h7FFF_FFFF; cz = 32'h7FFF_FFFF; end
                1: begin cx = 32'h8000_0000; cy = 32'h8000_0000; cz = 32'h8000_0000; end
                default: begin cx = $urandom; cy = $urandom; cz = $urandom; end
            endcase
            case (p)
                0:       inv = 32'h0000_0001;
                1:       inv = 32'hFFFF_FFFF;
                2:       inv = 32'h0001_0000;
                3:       inv = $urandom_range(1 << 20, 1 << 12);
                4:       inv = 32'h8000_0000;
                5:       inv = $urandom;
                6:       inv = $urandom_range(1 << 18, 1 << 14);
                7:       inv = 32'h0002_0000;
                8:       inv = 32'h0000_0000;
                default: inv = $urandom_range(1 << 24, 1 << 8);
            endcase
            apply_config(cx, cy, cz, inv, 2'((p % 3) + 1));
            if (p < 4)
                set_idling(30, 88);
            else if (p < 7)
                set_idling(88, 30);
            else
                set_idling(0, 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
                push_random_point();
            // The receiver stops for a long stretch while points keep coming.
            if (p == 7)
                hold_armed = 1'b1;
            wait_drained();
        end

        repeat (20) @(negedge aclk);
        $display("Sent %0d points under %0d register settings plus the reset defaults.",
                 points_queued, config_count);
        $display("Checked %0d results, %0d bad, %0d still outstanding.",
                 results_seen, bad_results, predicted_kernels.size());
        if (bad_results == 0 && predicted_kernels.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("Run timed out with %0d of %0d results seen.", results_seen, points_queued);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== bspline_box_kernel_eval.f =====
rtl/bsk_pkg.sv
rtl/bsk_axis_lane.sv
rtl/bsk_combine.sv
rtl/bspline_box_kernel_eval.sv
tb/bspline_box_kernel_eval_test.sv
